@@ sv/assert_macros.svh @@
// Assertion macros of the palette scaler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PVPS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pvps assertion failed");

// A condition that forces a consequence in the same cycle.
`define PVPS_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pvps assertion failed");

`endif

@@ sv/pvps_pkg.sv @@
// Package of the palette scaler: types, register codes, reset colours and
// the channel average function. Depends on nothing.
package pvps_pkg;

   localparam int unsigned RGB_W = 24;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [1:0] MODE_PLAIN0 = 2'd0;
   localparam logic [1:0] MODE_PLAIN1 = 2'd1;
   localparam logic [1:0] MODE_TRIPLE = 2'd2;
   localparam logic [1:0] MODE_DOUBLE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE3 = 3'd4;

   localparam logic [RGB_W-1:0] PALETTE0_RESET = 24'h000000;
   localparam logic [RGB_W-1:0] PALETTE1_RESET = 24'hB0B0B0;
   localparam logic [RGB_W-1:0] PALETTE2_RESET = 24'h404040;
   localparam logic [RGB_W-1:0] PALETTE3_RESET = 24'hFFFFFF;

   localparam logic [RGB_W-1:0] AVG_MASK = 24'hFEFEFF;

   typedef logic [RGB_W-1:0] rgb_type;
   typedef rgb_type [3:0] palette_type;

   typedef struct packed {
      logic [1:0] row;
      logic [3:0] col;
      logic [1:0] pair;
      logic [1:0] phase;
   } pos_type;

   function automatic rgb_type avg_rgb(input rgb_type a, input rgb_type b);
      logic [RGB_W:0] sum;
      sum = {1'b0, a & AVG_MASK} + {1'b0, b & AVG_MASK};
      return sum[RGB_W:1];
   endfunction

endpackage

@@ sv/pvps_pixel.sv @@
// Colour of one output pixel from the held word pair and its block position.
// Depends on pvps_pkg for the palette, position type and average function.
module pvps_pixel (
   input  logic [pvps_pkg::WORD_W-1:0] word_top,
   input  logic [pvps_pkg::WORD_W-1:0] word_bottom,
   input  pvps_pkg::palette_type       palette,
   input  logic [1:0]                  scale_mode,
   input  pvps_pkg::pos_type           pos,
   output pvps_pkg::rgb_type           pixel_rgb
);
   import pvps_pkg::*;

   function automatic rgb_type colour_of(input logic [WORD_W-1:0] w, input logic [2:0] k,
                                         input palette_type pal);
      logic [7:0] plane0;
      logic [7:0] plane1;
      plane0 = w[7:0];
      plane1 = w[15:8];
      return pal[{plane1[3'd7 - k], plane0[3'd7 - k]}];
   endfunction

   rgb_type plain_rgb;
   rgb_type double_rgb;
   rgb_type ta;
   rgb_type tb;
   rgb_type ua;
   rgb_type ub;
   rgb_type tab;
   rgb_type uab;
   rgb_type triple_rgb;

   assign plain_rgb = colour_of((pos.row == 2'd0) ? word_top : word_bottom, pos.col[2:0],
                                palette);
   assign double_rgb = colour_of(pos.row[1] ? word_bottom : word_top, pos.col[3:1], palette);

   assign ta = colour_of(word_top, {pos.pair, 1'b0}, palette);
   assign tb = colour_of(word_top, {pos.pair, 1'b1}, palette);
   assign ua = colour_of(word_bottom, {pos.pair, 1'b0}, palette);
   assign ub = colour_of(word_bottom, {pos.pair, 1'b1}, palette);
   assign tab = avg_rgb(ta, tb);
   assign uab = avg_rgb(ua, ub);

   always_comb begin
      case ({pos.row, pos.phase})
         {2'd0, 2'd0}: triple_rgb = ta;
         {2'd0, 2'd1}: triple_rgb = tab;
         {2'd0, 2'd2}: triple_rgb = tb;
         {2'd1, 2'd0}: triple_rgb = avg_rgb(ta, ua);
         {2'd1, 2'd1}: triple_rgb = avg_rgb(tab, uab);
         {2'd1, 2'd2}: triple_rgb = avg_rgb(tb, ub);
         {2'd2, 2'd0}: triple_rgb = ua;
         {2'd2, 2'd1}: triple_rgb = uab;
         {2'd2, 2'd2}: triple_rgb = ub;
         default:      triple_rgb = ta;
      endcase
   end

   always_comb begin
      case (scale_mode)
         MODE_TRIPLE: pixel_rgb = triple_rgb;
         MODE_DOUBLE: pixel_rgb = double_rgb;
         default:     pixel_rgb = plain_rgb;
      endcase
   end

endmodule

@@ sv/planar_video_palette_scaler_unit.sv @@
// Planar two-bit video to RGB expander with 1x, 3/2 and 2x scaling.
// Depends on pvps_pkg, pvps_pixel and assert_macros.svh.
//
// Each request on req_ carries a pair of video words, the top row word in
// tdata[15:0] and the next row word in tdata[31:16]. The block answers with
// the pixels of each request on rsp_, row by row and left to right, with tlast
// on the final pixel of the pair. Scale mode 0 or 1 gives 16 pixels, mode 2
// gives 36 and mode 3 gives 64; the output channel carries a single pixel
// a cycle while rsp_tready does not stall it.
// The word pair is registered when the request is taken and each pixel in
// the output register. The next request is taken in the cycle that computes
// the final pixel of the current one, so pairs stream without a gap.
// A stall on rsp_tready holds the output register and freezes the pixel
// sequence; req_tready stays low until the final pixel can be produced.
// The user must write registers through csr_ only while the block is idle; the block
// does not enforce this. Reset empties both stages and restores mode 0 and the default palette.
module planar_video_palette_scaler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // word_top [15:0], word_bottom [31:16]
   input  logic [31:0]                      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_rgb [23:0], out_row [25:24], out_col [29:26], zero fill [31:30]
   output logic [31:0]                      rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_wen,
   input  logic [pvps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pvps_pkg::RGB_W-1:0]       csr_wdata
);
   import pvps_pkg::*;

   logic [1:0]           mode_ff;
   palette_type          palette_ff;
   logic                 busy_ff;
   logic [WORD_W-1:0]    top_ff;
   logic [WORD_W-1:0]    bottom_ff;
   pos_type              pos_ff;
   pos_type              pos_in;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;
   logic                 rsp_last_ff;
   rgb_type              pixel_rgb;
   logic                 out_free;
   logic                 advance;
   logic                 is_last;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN0;
         palette_ff[0] <= PALETTE0_RESET;
         palette_ff[1] <= PALETTE1_RESET;
         palette_ff[2] <= PALETTE2_RESET;
         palette_ff[3] <= PALETTE3_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SCALE_MODE: mode_ff <= csr_wdata[1:0];
            CSR_PALETTE0:   palette_ff[0] <= csr_wdata;
            CSR_PALETTE1:   palette_ff[1] <= csr_wdata;
            CSR_PALETTE2:   palette_ff[2] <= csr_wdata;
            CSR_PALETTE3:   palette_ff[3] <= csr_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_TRIPLE: is_last = (pos_ff.row == 2'd2) && (pos_ff.col == 4'd11);
         MODE_DOUBLE: is_last = (pos_ff.row == 2'd3) && (pos_ff.col == 4'd15);
         default:     is_last = (pos_ff.row == 2'd1) && (pos_ff.col == 4'd7);
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = busy_ff && out_free;
   assign req_tready = !busy_ff || (advance && is_last);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      pos_in = pos_ff;
      case (mode_ff)
         MODE_TRIPLE: begin
            if (pos_ff.col == 4'd11) begin
               pos_in.col = 4'd0;
               pos_in.row = pos_ff.row + 2'd1;
            end else begin
               pos_in.col = pos_ff.col + 4'd1;
            end
            if (pos_ff.phase == 2'd2) begin
               pos_in.phase = 2'd0;
               pos_in.pair = pos_ff.pair + 2'd1;
            end else begin
               pos_in.phase = pos_ff.phase + 2'd1;
            end
         end
         MODE_DOUBLE: begin
            pos_in.col = pos_ff.col + 4'd1;
            if (pos_ff.col == 4'd15) begin
               pos_in.row = pos_ff.row + 2'd1;
            end
         end
         default: begin
            if (pos_ff.col == 4'd7) begin
               pos_in.col = 4'd0;
               pos_in.row = pos_ff.row + 2'd1;
            end else begin
               pos_in.col = pos_ff.col + 4'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         pos_ff <= '0;
      end else if (advance) begin
         if (is_last) begin
            busy_ff <= 1'b0;
         end
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff <= req_tdata[15:0];
         bottom_ff <= req_tdata[31:16];
      end
   end

   pvps_pixel u_pixel (
      .word_top    (top_ff),
      .word_bottom (bottom_ff),
      .palette     (palette_ff),
      .scale_mode  (mode_ff),
      .pos         (pos_ff),
      .pixel_rgb   (pixel_rgb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, pos_ff.col, pos_ff.row, pixel_rgb};
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

`include "assert_macros.svh"

   `PVPS_ASSERT_IMPLIES(a_req_only_at_end, clock, reset, busy_ff && req_tready, advance && is_last)
   `PVPS_ASSERT_IMPLIES(a_last_position, clock, reset, rsp_valid_ff && rsp_last_ff && mode_ff == MODE_TRIPLE, rsp_data_ff[25:24] == 2'd2 && rsp_data_ff[29:26] == 4'd11)
   `PVPS_ASSERT_IMPLIES(a_triple_range, clock, reset, busy_ff && mode_ff == MODE_TRIPLE, pos_ff.row != 2'd3 && pos_ff.phase != 2'd3 && pos_ff.col < 4'd12)
   `PVPS_ASSERT_ALWAYS(a_plain_range, clock, reset, !(busy_ff && (mode_ff == MODE_PLAIN0 || mode_ff == MODE_PLAIN1)) || (!pos_ff.row[1] && !pos_ff.col[3]))

endmodule

@@ tb/tb_planar_video_palette_scaler_unit.sv @@
// Self-checking testbench of the planar palette scaler unit: it drives video
// word pairs and register writes and predicts every pixel in a small class.
// Depends on pvps_pkg and planar_video_palette_scaler_unit.
`timescale 1ns / 1ps

module tb_planar_video_palette_scaler_unit;
   import pvps_pkg::*;

   typedef struct packed {
      logic [23:0] rgb;
      logic [1:0]  row;
      logic [3:0]  col;
      logic        last;
   } pixel_type;

   class pixel_ledger;
      logic [1:0]  mode;
      logic [23:0] palette [4];
      pixel_type   due_pixels [$];
      int unsigned errors;
      int unsigned pairs;
      int unsigned pixels;
      int unsigned pairs_in_mode [4];

      function new();
         mode = MODE_PLAIN0;
         palette[0] = 24'h000000;
         palette[1] = 24'hB0B0B0;
         palette[2] = 24'h404040;
         palette[3] = 24'hFFFFFF;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [23:0] value);
         case (index)
            CSR_SCALE_MODE: mode = value[1:0];
            CSR_PALETTE0:   palette[0] = value;
            CSR_PALETTE1:   palette[1] = value;
            CSR_PALETTE2:   palette[2] = value;
            CSR_PALETTE3:   palette[3] = value;
            default: ;
         endcase
      endfunction

      function logic [23:0] colour(logic [15:0] word, int k);
         logic [2:0] bit_pos;
         bit_pos = 3'(7 - k);
         return palette[{word[{1'b1, bit_pos}], word[{1'b0, bit_pos}]}];
      endfunction

      // Red and green lose their low bits before the sum; blue keeps its low bit.
      function logic [23:0] blend(logic [23:0] a, logic [23:0] b);
         logic [24:0] sum;
         sum = {1'b0, a & 24'hFEFEFF} + {1'b0, b & 24'hFEFEFF};
         return sum[24:1];
      endfunction

      function void push(logic [23:0] rgb, int row, int col);
         pixel_type px;
         px.rgb = rgb;
         px.row = row[1:0];
         px.col = col[3:0];
         px.last = 1'b0;
         due_pixels.push_back(px);
      endfunction

      function void expand_pair(logic [15:0] top, logic [15:0] bottom);
         logic [23:0] ta, tb, ua, ub, tab, uab, c0, c1, c2;
         pairs++;
         pairs_in_mode[mode]++;
         case (mode)
            MODE_TRIPLE: begin
               for (int r = 0; r < 3; r++) begin
                  for (int p = 0; p < 4; p++) begin
                     ta = colour(top, 2 * p);
                     tb = colour(top, 2 * p + 1);
                     ua = colour(bottom, 2 * p);
                     ub = colour(bottom, 2 * p + 1);
                     tab = blend(ta, tb);
                     uab = blend(ua, ub);
                     case (r)
                        0: begin
                           c0 = ta; c1 = tab; c2 = tb;
                        end
                        1: begin
                           c0 = blend(ta, ua); c1 = blend(tab, uab); c2 = blend(tb, ub);
                        end
                        default: begin
                           c0 = ua; c1 = uab; c2 = ub;
                        end
                     endcase
                     push(c0, r, 3 * p);
                     push(c1, r, 3 * p + 1);
                     push(c2, r, 3 * p + 2);
                  end
               end
            end
            MODE_DOUBLE: begin
               for (int r = 0; r < 4; r++) begin
                  for (int k = 0; k < 8; k++) begin
                     c0 = colour((r < 2) ? top : bottom, k);
                     push(c0, r, 2 * k);
                     push(c0, r, 2 * k + 1);
                  end
               end
            end
            default: begin
               for (int r = 0; r < 2; r++) begin
                  for (int k = 0; k < 8; k++) begin
                     push(colour((r == 0) ? top : bottom, k), r, k);
                  end
               end
            end
         endcase
         due_pixels[due_pixels.size() - 1].last = 1'b1;
      endfunction

      function void match_pixel(logic [31:0] data, logic last);
         pixel_type want;
         pixels++;
         if (due_pixels.size() == 0) begin
            $error("pixel with nothing due: tdata %h, tlast %b", data, last);
            errors++;
            return;
         end
         want = due_pixels.pop_front();
         if (data[23:0] !== want.rgb) begin
            $error("pixel_rgb: expected %h, actual %h", want.rgb, data[23:0]);
            errors++;
         end
         if (data[25:24] !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, data[25:24]);
            errors++;
         end
         if (data[29:26] !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, data[29:26]);
            errors++;
         end
         if (data[31:30] !== 2'b00) begin
            $error("zero fill: expected 0, actual %b", data[31:30]);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_item: expected %b, actual %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [RGB_W-1:0]       csr_wdata = '0;
   logic                   steady = 1'b0;

   pixel_ledger ledger = new();

   planar_video_palette_scaler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic bit idle_roll();
      return !steady && ($urandom_range(99) < 29);
   endfunction

   always @(posedge clock) begin
      rsp_tready <= !reset && !idle_roll();
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         ledger.expand_pair(req_tdata[15:0], req_tdata[31:16]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.match_pixel(rsp_tdata, rsp_tlast);
      end
      if (!reset && csr_wen) begin
         ledger.write_reg(csr_index, csr_wdata);
      end
   end

   task automatic send_pair(input logic [15:0] top, input logic [15:0] bottom);
      if (idle_roll()) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (idle_roll());
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bottom, top};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ledger.due_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic drive_csr(input logic [CSR_INDEX_W-1:0] index, input logic [23:0] value);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes every register, plus one write to an unused index that must be ignored.
   task automatic apply_setting(input logic [1:0] mode, input logic [3:0][23:0] colours);
      logic [23:0] mode_word;
      logic [CSR_INDEX_W-1:0] spare;
      mode_word = 24'($urandom());
      mode_word[1:0] = mode;
      spare = CSR_PALETTE3 + CSR_INDEX_W'(1 + $urandom_range(2));
      drain();
      drive_csr(spare, 24'($urandom()));
      drive_csr(CSR_SCALE_MODE, mode_word);
      drive_csr(CSR_PALETTE0, colours[0]);
      drive_csr(CSR_PALETTE1, colours[1]);
      drive_csr(CSR_PALETTE2, colours[2]);
      drive_csr(CSR_PALETTE3, colours[3]);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [23:0] pick_colour();
      case ($urandom_range(7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   initial begin
      logic [31:0] plain_pairs [5] = '{32'hFFFF_0000, 32'h0000_FFFF, 32'hFF00_00FF,
                                       32'h0180_8001, 32'hAAAA_5555};
      logic [31:0] triple_pairs [4] = '{32'hFF00_00FF, 32'hE4E4_1B1B, 32'hAA55_55AA,
                                        32'hFFFF_FFFF};
      logic [31:0] double_pairs [3] = '{32'h0080_8000, 32'h0100_0001, 32'hE4E4_1B1B};
      logic [1:0] modes [4] = '{MODE_PLAIN0, MODE_PLAIN1, MODE_TRIPLE, MODE_DOUBLE};
      logic [3:0][23:0] colours;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset palette and plain mode first, without any register write.
      foreach (plain_pairs[i]) send_pair(plain_pairs[i][15:0], plain_pairs[i][31:16]);

      apply_setting(MODE_PLAIN1, {24'hFEDCBA, 24'h123456, 24'hFFFFFF, 24'h000000});
      send_pair(16'h1B1B, 16'hE4E4);
      send_pair(16'hFFFF, 16'h0000);

      // Colours chosen so that the averages show the dropped low bits.
      apply_setting(MODE_TRIPLE, {24'hFEFF01, 24'h010101, 24'hFFFFFF, 24'h000000});
      foreach (triple_pairs[i]) send_pair(triple_pairs[i][15:0], triple_pairs[i][31:16]);

      apply_setting(MODE_DOUBLE, {24'hFFFFFF, 24'h404040, 24'hB0B0B0, 24'h000000});
      foreach (double_pairs[i]) send_pair(double_pairs[i][15:0], double_pairs[i][31:16]);

      for (int phase = 0; phase < 10; phase++) begin
         for (int c = 0; c < 4; c++) colours[2'(c)] = pick_colour();
         if (phase == 8) colours = {4{24'hFFFFFF}};
         if (phase == 9) colours = '0;
         apply_setting(modes[2'(phase % 4)], colours);
         steady <= (phase == 6);
         repeat (46) send_pair(pick_word(), pick_word());
      end

      drain();
      $display("Checked %0d word pairs as %0d pixels over scale modes 0..3: %0d/%0d/%0d/%0d.",
               ledger.pairs, ledger.pixels, ledger.pairs_in_mode[0], ledger.pairs_in_mode[1],
               ledger.pairs_in_mode[2], ledger.pairs_in_mode[3]);
      if (ledger.errors == 0 && ledger.due_pixels.size() == 0) begin
         $display("planar_video_palette_scaler_unit: match");
      end else begin
         $display("planar_video_palette_scaler_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d pixels still due.", ledger.due_pixels.size());
      $display("planar_video_palette_scaler_unit: mismatch");
      $finish;
   end

endmodule
